/* src/srsw_pkg.sv */
// shared types, constants and helper functions for the selective-repeat sender window
// used by srsw_csr, srsw_ctrl, srsw_dp and selective_repeat_sender_window
package srsw_pkg;

   localparam int CHUNK_BYTES = 512;
   localparam int CHUNK_SHIFT = 9;
   localparam int MAX_WINDOW  = 8;
   localparam int SLOT_W      = 3;
   localparam int MAX_PACKETS = 65536;

   localparam int KIND_W      = 2;
   localparam int SEQ_W       = 16;
   localparam int LEN_W       = 10;
   localparam int PKT_W       = 17;
   localparam int TOTAL_W     = 26;
   localparam int WIN_W       = 4;
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 26;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [TOTAL_W-1:0] TOTAL_LENGTH_RESET  = '0;
   localparam logic [WIN_W-1:0]   WINDOW_SIZE_RESET   = 4'd3;
   localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RESET = 16'd100;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_length;
      logic [WIN_W-1:0]   window_size;
      logic [TICK_W-1:0]  timeout_ticks;
   } csr_type;

   typedef struct packed {
      logic start;
      logic mark_ack;
      logic shift;
      logic plan_send;
      logic plan_tick;
      logic plan_teardown;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic slide_more;
      logic base_done;
      logic emit_empty;
      logic out_free;
   } sts_type;

   function automatic logic [PKT_W-1:0] packet_count(input logic [TOTAL_W-1:0] total);
      logic [PKT_W:0] n;
      n = (PKT_W+1)'(total >> CHUNK_SHIFT) + (PKT_W+1)'(|total[CHUNK_SHIFT-1:0]);
      if (n > (PKT_W+1)'(MAX_PACKETS)) begin
         n = (PKT_W+1)'(MAX_PACKETS);
      end
      return n[PKT_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] chunk_len(input logic [TOTAL_W-1:0] total,
                                                  input logic [PKT_W-1:0] pkt);
      logic [TOTAL_W-1:0] off;
      logic [TOTAL_W-1:0] rem;
      off = TOTAL_W'({pkt, {CHUNK_SHIFT{1'b0}}});
      rem = total - off;
      if (off >= total) begin
         return '0;
      end else if (rem >= TOTAL_W'(CHUNK_BYTES)) begin
         return LEN_W'(CHUNK_BYTES);
      end else begin
         return LEN_W'(total[CHUNK_SHIFT-1:0]);
      end
   endfunction

endpackage

/* src/srsw_csr.sv */
// configuration registers: total length, window size and timeout
// depends on srsw_pkg
module srsw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srsw_pkg::CSR_DATA_W-1:0]  csr_data,
   output srsw_pkg::csr_type                csr
);

   srsw_pkg::csr_type csr_ff;
   srsw_pkg::csr_type csr_in;

   assign csr_ready = 1'b1;
   assign csr       = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            srsw_pkg::REG_TOTAL_LENGTH: begin
               csr_in.total_length = csr_data[srsw_pkg::TOTAL_W-1:0];
            end
            srsw_pkg::REG_WINDOW_SIZE: begin
               csr_in.window_size = csr_data[srsw_pkg::WIN_W-1:0];
            end
            srsw_pkg::REG_TIMEOUT_TICKS: begin
               csr_in.timeout_ticks = csr_data[srsw_pkg::TICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.total_length  <= srsw_pkg::TOTAL_LENGTH_RESET;
         csr_ff.window_size   <= srsw_pkg::WINDOW_SIZE_RESET;
         csr_ff.timeout_ticks <= srsw_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule

/* src/srsw_ctrl.sv */
// controller state machine: sequences ack marking, base sliding, planning and emission
// depends on srsw_pkg
module srsw_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srsw_pkg::KIND_W-1:0]    req_kind,
   input  srsw_pkg::sts_type              sts,
   output srsw_pkg::cmd_type              cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SLIDE = 4'b0010,
      ST_PLAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      tick_mode_ff;
   logic      tick_mode_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      tick_mode_in = tick_mode_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  srsw_pkg::KIND_START: begin
                     cmd.start    = 1'b1;
                     tick_mode_in = 1'b0;
                     state_in     = ST_PLAN;
                  end
                  srsw_pkg::KIND_ACK: begin
                     if (!sts.done) begin
                        cmd.mark_ack = 1'b1;
                        state_in     = ST_SLIDE;
                     end
                  end
                  srsw_pkg::KIND_TICK: begin
                     if (!sts.done) begin
                        tick_mode_in = 1'b1;
                        state_in     = ST_PLAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SLIDE: begin
            if (sts.slide_more) begin
               cmd.shift = 1'b1;
            end else if (sts.base_done) begin
               cmd.plan_teardown = 1'b1;
               state_in          = ST_EMIT;
            end else begin
               tick_mode_in = 1'b0;
               state_in     = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (tick_mode_ff) begin
               cmd.plan_tick = 1'b1;
            end else begin
               cmd.plan_send = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.emit_empty) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_load = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_mode_ff <= tick_mode_in;
      end
   end

endmodule

/* src/srsw_dp.sv */
// datapath: window base, per-slot acked/sent marks and timers, emit mask and result register
// depends on srsw_pkg
module srsw_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  srsw_pkg::csr_type                 csr,
   input  logic [srsw_pkg::SEQ_W-1:0]        ack_seq,
   input  srsw_pkg::cmd_type                 cmd,
   output srsw_pkg::sts_type                 sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srsw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [srsw_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int NW = srsw_pkg::MAX_WINDOW;

   logic [srsw_pkg::PKT_W-1:0]   base_ff, base_in;
   logic [NW-1:0]                acked_ff, acked_in;
   logic [NW-1:0]                sent_ff, sent_in;
   logic [srsw_pkg::TICK_W-1:0]  timer_ff [NW];
   logic [srsw_pkg::TICK_W-1:0]  timer_in [NW];
   logic                         done_ff, done_in;
   logic [NW-1:0]                mask_ff, mask_in;
   logic                         resend_ff, resend_in;
   logic                         td_ff, td_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [srsw_pkg::SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [srsw_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                         rsp_resend_ff, rsp_resend_in;
   logic                         rsp_td_ff, rsp_td_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [srsw_pkg::PKT_W-1:0]   npk;
   logic [srsw_pkg::WIN_W-1:0]   win;
   logic [srsw_pkg::PKT_W-1:0]   pkt [NW];
   logic [NW-1:0]                in_win;
   logic [NW-1:0]                send_m;
   logic [NW-1:0]                tick_m;
   logic [NW-1:0]                expire_m;
   logic [srsw_pkg::PKT_W-1:0]   ack_ext;
   logic [srsw_pkg::PKT_W-1:0]   ack_off;
   logic [srsw_pkg::SLOT_W-1:0]  ack_idx;
   logic                         ack_hit;
   logic [srsw_pkg::SLOT_W-1:0]  sel;
   logic [NW-1:0]                rest;

   assign npk = srsw_pkg::packet_count(csr.total_length);

   always_comb begin
      if (csr.window_size == '0) begin
         win = srsw_pkg::WIN_W'(1);
      end else if (csr.window_size > srsw_pkg::WIN_W'(NW)) begin
         win = srsw_pkg::WIN_W'(NW);
      end else begin
         win = csr.window_size;
      end
   end

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         pkt[i]      = base_ff + srsw_pkg::PKT_W'(i);
         in_win[i]   = (srsw_pkg::WIN_W'(i) < win) && (pkt[i] < npk);
         send_m[i]   = in_win[i] && !sent_ff[i] && !acked_ff[i];
         tick_m[i]   = in_win[i] && sent_ff[i] && !acked_ff[i];
         expire_m[i] = tick_m[i] && (timer_ff[i] <= srsw_pkg::TICK_W'(1));
      end
   end

   assign ack_ext = srsw_pkg::PKT_W'(ack_seq);
   assign ack_off = ack_ext - base_ff;
   assign ack_idx = ack_off[srsw_pkg::SLOT_W-1:0];
   assign ack_hit = (ack_ext >= base_ff) && (ack_off < srsw_pkg::PKT_W'(win))
                    && (ack_ext < npk) && !acked_ff[ack_idx];

   // lowest pending slot goes out first
   always_comb begin
      sel = '0;
      for (int i = NW - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = srsw_pkg::SLOT_W'(i);
         end
      end
      rest      = mask_ff;
      rest[sel] = 1'b0;
   end

   assign sts.done       = done_ff;
   assign sts.slide_more = (base_ff < npk) && acked_ff[0];
   assign sts.base_done  = (base_ff >= npk);
   assign sts.emit_empty = (mask_ff == '0) && !td_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      base_in       = base_ff;
      acked_in      = acked_ff;
      sent_in       = sent_ff;
      timer_in      = timer_ff;
      done_in       = done_ff;
      mask_in       = mask_ff;
      resend_in     = resend_ff;
      td_in         = td_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_resend_in = rsp_resend_ff;
      rsp_td_in     = rsp_td_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.start) begin
         base_in  = '0;
         acked_in = '0;
         sent_in  = '0;
         done_in  = 1'b0;
         for (int i = 0; i < NW; i++) begin
            timer_in[i] = '0;
         end
      end

      if (cmd.mark_ack && ack_hit) begin
         acked_in[ack_idx] = 1'b1;
         timer_in[ack_idx] = '0;
      end

      // slide base by one packet
      if (cmd.shift) begin
         acked_in = acked_ff >> 1;
         sent_in  = sent_ff >> 1;
         for (int i = 0; i < NW - 1; i++) begin
            timer_in[i] = timer_ff[i+1];
         end
         timer_in[NW-1] = '0;
         base_in        = base_ff + srsw_pkg::PKT_W'(1);
      end

      if (cmd.plan_send) begin
         sent_in   = sent_ff | send_m;
         mask_in   = send_m;
         resend_in = 1'b0;
         td_in     = (npk == '0);
         if (npk == '0) begin
            done_in = 1'b1;
         end
         for (int i = 0; i < NW; i++) begin
            if (send_m[i]) begin
               timer_in[i] = csr.timeout_ticks;
            end
         end
      end

      if (cmd.plan_tick) begin
         mask_in   = expire_m;
         resend_in = 1'b1;
         td_in     = 1'b0;
         for (int i = 0; i < NW; i++) begin
            if (expire_m[i]) begin
               timer_in[i] = csr.timeout_ticks;
            end else if (tick_m[i]) begin
               timer_in[i] = timer_ff[i] - srsw_pkg::TICK_W'(1);
            end
         end
      end

      if (cmd.plan_teardown) begin
         mask_in   = '0;
         resend_in = 1'b0;
         td_in     = 1'b1;
         done_in   = 1'b1;
      end

      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         if (mask_ff != '0) begin
            rsp_seq_in    = pkt[sel][srsw_pkg::SEQ_W-1:0];
            rsp_len_in    = srsw_pkg::chunk_len(csr.total_length, pkt[sel]);
            rsp_resend_in = resend_ff;
            rsp_td_in     = 1'b0;
            rsp_last_in   = (rest == '0) && !td_ff;
            mask_in       = rest;
         end else begin
            rsp_seq_in    = '0;
            rsp_len_in    = '0;
            rsp_resend_in = 1'b0;
            rsp_td_in     = 1'b1;
            rsp_last_in   = 1'b1;
            td_in         = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         acked_ff     <= '0;
         sent_ff      <= '0;
         done_ff      <= 1'b1;
         mask_ff      <= '0;
         resend_ff    <= 1'b0;
         td_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NW; i++) begin
            timer_ff[i] <= '0;
         end
      end else begin
         base_ff      <= base_in;
         acked_ff     <= acked_in;
         sent_ff      <= sent_in;
         done_ff      <= done_in;
         mask_ff      <= mask_in;
         resend_ff    <= resend_in;
         td_ff        <= td_in;
         rsp_valid_ff <= rsp_valid_in;
         timer_ff     <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_seq_ff    <= rsp_seq_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_resend_ff <= rsp_resend_in;
      rsp_td_ff     <= rsp_td_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(srsw_pkg::RSP_DATA_W - srsw_pkg::SEQ_W - srsw_pkg::LEN_W){1'b0}},
                        rsp_len_ff, rsp_seq_ff};
   assign rsp_tuser  = {rsp_td_ff, rsp_resend_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* src/selective_repeat_sender_window.sv */
// top level of the selective-repeat sender window
// depends on srsw_pkg, srsw_csr, srsw_ctrl and srsw_dp
//
// Sender side of a selective-repeat transfer. Each req item is an event: start,
// acknowledgement or timer tick; each rsp item is a send command, a timeout resend or the
// final teardown, with tlast marking the last item caused by one event. Events are handled
// one at a time by a controller stepping a datapath that holds eight window slots. An event
// that is ignored (acknowledgement or tick once the transfer is done, unused kind) is
// simply accepted. A start or a tick is planned and then emits its results one at a time; an
// acknowledgement marks its slot, slides the base over each acknowledged packet at the front
// (at most eight, one slot per cycle), then plans, or tears down once the base passes the last
// packet, and then emits. req_tready is high only between events; the single result register
// lets the next event be taken while the last result waits. Configuration should be written
// only while no event is in progress; the block itself does not enforce this.
module selective_repeat_sender_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] ack_seq
   input  logic [srsw_pkg::KIND_W-1:0]       req_tuser,   // [1:0] kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srsw_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] send_seq, [25:16] send_length
   output logic [srsw_pkg::RSP_USER_W-1:0]   rsp_tuser,   // [0] is_resend, [1] is_teardown
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srsw_pkg::CSR_DATA_W-1:0]   csr_data
);

   srsw_pkg::csr_type csr;
   srsw_pkg::cmd_type cmd;
   srsw_pkg::sts_type sts;

   srsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr       (csr)
   );

   srsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   srsw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .ack_seq    (req_tdata[srsw_pkg::SEQ_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
